### hw/rtl/gtpvc_pkg.sv
// Shared constants for the go-to-pose velocity controller.
// No dependencies; every other file in hw/rtl uses it by scoped name.
`default_nettype none
package gtpvc_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int W_RS       = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
   localparam int W_LS       = (FRAC_BITS > 20) ? FRAC_BITS - 20 : 0;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int QUO_W      = 20;
   localparam int NUM_W      = 51;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 63;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LINEAR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINEAR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN     = 3'd4;

   localparam logic MODE_ODOM = 1'b0;
   localparam logic MODE_GOAL = 1'b1;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;
endpackage
`default_nettype wire

### hw/rtl/gtpvc_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on gtpvc_pkg.
`default_nettype none
module gtpvc_mul (
   input  wire logic                           clock,
   input  wire logic [gtpvc_pkg::MUL_W-1:0]    op_a,
   input  wire logic [gtpvc_pkg::MUL_W-1:0]    op_b,
   output logic      [gtpvc_pkg::PROD_W-1:0]   prod
);
   logic [gtpvc_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= gtpvc_pkg::PROD_W'(op_a) * gtpvc_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

### hw/rtl/gtpvc_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on gtpvc_pkg.
`default_nettype none
module gtpvc_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gtpvc_pkg::RAD_W-1:0]   radicand,
   output logic                               done,
   output logic      [gtpvc_pkg::ROOT_W-1:0]  root
);
   logic [33:0]                     rem_ff;
   logic [gtpvc_pkg::ROOT_W-1:0]    root_ff;
   logic [63:0]                     val_ff;
   logic [5:0]                      cnt_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [35:0]                     shifted;
   logic [35:0]                     trial;

   always_comb begin
      shifted = {rem_ff, val_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            root_ff <= '0;
            val_ff  <= {1'b0, radicand};
            cnt_ff  <= 6'd32;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (shifted >= trial) begin
               rem_ff  <= 34'(shifted - trial);
               root_ff <= {root_ff[gtpvc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= shifted[33:0];
               root_ff <= {root_ff[gtpvc_pkg::ROOT_W-2:0], 1'b0};
            end
            val_ff <= {val_ff[61:0], 2'b00};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### hw/rtl/gtpvc_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
// Depends on gtpvc_pkg.
`default_nettype none
module gtpvc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gtpvc_pkg::unit_ctl_type       ctl_in,
   input  wire logic [gtpvc_pkg::NUM_W-1:0]   numer,
   input  wire logic [gtpvc_pkg::ROOT_W-1:0]  denom,
   output gtpvc_pkg::unit_ctl_type            ctl_out,
   output logic      [gtpvc_pkg::QUO_W-1:0]   quot
);
   localparam int HI_W = gtpvc_pkg::NUM_W - gtpvc_pkg::QUO_W;

   logic [gtpvc_pkg::ROOT_W-1:0]  rem_ff;
   logic [gtpvc_pkg::QUO_W-1:0]   low_ff;
   logic [gtpvc_pkg::QUO_W-1:0]   quot_ff;
   logic [4:0]                    cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [gtpvc_pkg::ROOT_W:0]    trial;

   assign trial = {rem_ff, low_ff[gtpvc_pkg::QUO_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl_in.start) begin
            rem_ff  <= gtpvc_pkg::ROOT_W'(numer[gtpvc_pkg::NUM_W-1 -: HI_W]);
            low_ff  <= numer[gtpvc_pkg::QUO_W-1:0];
            quot_ff <= '0;
            cnt_ff  <= 5'(gtpvc_pkg::QUO_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (trial >= {1'b0, denom}) begin
               rem_ff  <= gtpvc_pkg::ROOT_W'(trial - {1'b0, denom});
               quot_ff <= {quot_ff[gtpvc_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_ff  <= trial[gtpvc_pkg::ROOT_W-1:0];
               quot_ff <= {quot_ff[gtpvc_pkg::QUO_W-2:0], 1'b0};
            end
            low_ff <= {low_ff[gtpvc_pkg::QUO_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      ctl_out       = '0;
      ctl_out.start = busy_ff;
      ctl_out.done  = done_ff;
   end
   assign quot = quot_ff;
endmodule
`default_nettype wire

### hw/rtl/go_to_pose_velocity_controller_unit.sv
// Top level of the go-to-pose velocity controller: sequencer, pose and CSRs.
// Depends on gtpvc_pkg, gtpvc_mul, gtpvc_sqrt and gtpvc_div.
//
//   channel  dir  handshake            word
//   req_     in   req_valid/req_ready  mode, coord_x, coord_y, angle, tolerance
//   rsp_     out  rsp_valid/rsp_ready  vel_x, vel_y, turn_rate, still_moving
//   csr_     in   csr_wen              csr_index, csr_wdata (no read-back)
//
// An odometry word is absorbed in the cycle it is accepted and yields no response.
// A goal word holds the sequencer for eight passes through the shared 32x32 multiplier,
// the normalize steps, a square root wait and two divide waits; zero linear gain or zero
// distance skips straight to the final step. req_ready is high only in idle.
// The response register holds its word until taken; the final step stalls while an
// earlier response is still waiting. Reset is synchronous.
`default_nettype none
module go_to_pose_velocity_controller_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_mode,
   input  wire logic signed [31:0]                  req_coord_x,
   input  wire logic signed [31:0]                  req_coord_y,
   input  wire logic signed [15:0]                  req_angle,
   input  wire logic [30:0]                         req_tolerance,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [31:0]                       rsp_vel_x,
   output logic signed [31:0]                       rsp_vel_y,
   output logic signed [31:0]                       rsp_turn_rate,
   output logic                                     rsp_still_moving,
   input  wire logic                                csr_wen,
   input  wire logic [gtpvc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gtpvc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE, S_AX, S_AY, S_TOL, S_CMP, S_W, S_WCAP, S_NORM, S_NX, S_NY, S_SUM,
      S_SQ, S_SQW, S_MX, S_DX, S_DXW, S_MY, S_DY, S_DYW, S_OUT
   } state_type;

   localparam logic [63:0] W_LIM = 64'h0000_0000_7FFF_FFFF;

   state_type state_ff;

   // configuration
   logic [15:0] lin_gain_ff, head_gain_ff;
   logic [19:0] min_lin_ff, max_lin_ff, min_turn_ff;

   // pose
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] pose_h_ff;

   // working registers for one goal
   logic [31:0] ax_ff, ay_ff;
   logic        dx_neg_ff, dy_neg_ff, e_neg_ff;
   logic [16:0] e_mag_ff;
   logic [30:0] tol_ff;
   logic [63:0] acc_ff;
   logic [31:0] m_ff;
   logic [19:0] vx_ff, vy_ff;
   logic [30:0] w_ff;
   logic        moving_ff;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] vel_x_ff, vel_y_ff, turn_ff;
   logic        still_ff;

   // shared multiplier operands
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   // goal capture
   logic signed [32:0] dx, dy;
   logic signed [16:0] de;
   logic [31:0]        big;
   logic [63:0]        w_shift;
   logic [19:0]        vx_db, vy_db;
   logic [30:0]        w_db;

   gtpvc_pkg::unit_ctl_type div_ctl, div_stat;
   logic                    sq_start, sq_done;
   logic [31:0]             sq_root;
   logic [19:0]             div_q;

   assign dx  = 33'(req_coord_x) - 33'(pose_x_ff);
   assign dy  = 33'(req_coord_y) - 33'(pose_y_ff);
   assign de  = 17'(req_angle) - 17'(pose_h_ff);
   assign big = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign w_shift = (prod >> gtpvc_pkg::W_RS) << gtpvc_pkg::W_LS;

   // drop components strictly inside the deadband
   assign vx_db = (vx_ff < min_lin_ff) ? 20'd0 : vx_ff;
   assign vy_db = (vy_ff < min_lin_ff) ? 20'd0 : vy_ff;
   assign w_db  = (31'(min_turn_ff) > w_ff) ? 31'd0 : w_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = ax_ff;
      mul_b = ax_ff;
      case (state_ff)
         S_AX, S_NX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         S_AY, S_NY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         S_TOL: begin
            mul_a = 32'(tol_ff);
            mul_b = 32'(tol_ff);
         end
         S_W: begin
            mul_a = 32'(e_mag_ff);
            mul_b = 32'(head_gain_ff);
         end
         S_MX: begin
            mul_a = 32'(max_lin_ff);
            mul_b = ax_ff;
         end
         S_MY: begin
            mul_a = 32'(max_lin_ff);
            mul_b = ay_ff;
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
      endcase
   end

   gtpvc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign sq_start = (state_ff == S_SQ);

   gtpvc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff[gtpvc_pkg::RAD_W-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_comb begin
      div_ctl       = '0;
      div_ctl.start = (state_ff == S_DX) || (state_ff == S_DY);
   end

   gtpvc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (div_ctl),
      .numer   (prod[gtpvc_pkg::NUM_W-1:0]),
      .denom   (m_ff),
      .ctl_out (div_stat),
      .quot    (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lin_gain_ff  <= 16'd256;
         head_gain_ff <= 16'd512;
         min_lin_ff   <= 20'd3277;
         max_lin_ff   <= 20'd13107;
         min_turn_ff  <= 20'd0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
      end else begin
         // register writes; unknown indexes are ignored
         if (csr_wen) begin
            case (csr_index)
               gtpvc_pkg::CSR_LINEAR_GAIN:  lin_gain_ff  <= csr_wdata[15:0];
               gtpvc_pkg::CSR_HEADING_GAIN: head_gain_ff <= csr_wdata[15:0];
               gtpvc_pkg::CSR_MIN_LINEAR:   min_lin_ff   <= csr_wdata;
               gtpvc_pkg::CSR_MAX_LINEAR:   max_lin_ff   <= csr_wdata;
               gtpvc_pkg::CSR_MIN_TURN:     min_turn_ff  <= csr_wdata;
               default: ;
            endcase
         end

         // drop the taken response unless the final step reloads it
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_mode == gtpvc_pkg::MODE_ODOM) begin
                     // odometry: store pose and stay idle
                     pose_x_ff <= req_coord_x;
                     pose_y_ff <= req_coord_y;
                     pose_h_ff <= req_angle;
                  end else begin
                     ax_ff     <= dx[32] ? 32'(-dx) : dx[31:0];
                     ay_ff     <= dy[32] ? 32'(-dy) : dy[31:0];
                     dx_neg_ff <= dx[32];
                     dy_neg_ff <= dy[32];
                     e_mag_ff  <= de[16] ? 17'(-de) : de;
                     e_neg_ff  <= de[16];
                     tol_ff    <= req_tolerance;
                     vx_ff     <= '0;
                     vy_ff     <= '0;
                     state_ff  <= S_AX;
                  end
               end
            end
            S_AX: state_ff <= S_AY;
            S_AY: begin
               acc_ff   <= prod;
               state_ff <= S_TOL;
            end
            S_TOL: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // distances of 2^31 or more always count as moving
               moving_ff <= ax_ff[31] | ay_ff[31] | (acc_ff > prod);
               state_ff  <= S_W;
            end
            S_W: state_ff <= S_WCAP;
            S_WCAP: begin
               w_ff <= (w_shift > W_LIM) ? W_LIM[30:0] : w_shift[30:0];
               if ((lin_gain_ff == 16'd0) || ((ax_ff | ay_ff) == 32'd0)) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               // bring the larger magnitude into [2^30, 2^31)
               if (big[31]) begin
                  ax_ff    <= ax_ff >> 1;
                  ay_ff    <= ay_ff >> 1;
                  state_ff <= S_NX;
               end else if (!big[30]) begin
                  ax_ff <= ax_ff << 1;
                  ay_ff <= ay_ff << 1;
               end else begin
                  state_ff <= S_NX;
               end
            end
            S_NX: state_ff <= S_NY;
            S_NY: begin
               acc_ff   <= prod;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= S_SQ;
            end
            S_SQ: state_ff <= S_SQW;
            S_SQW: begin
               if (sq_done) begin
                  m_ff     <= sq_root;
                  state_ff <= S_MX;
               end
            end
            S_MX: state_ff <= S_DX;
            S_DX: state_ff <= S_DXW;
            S_DXW: begin
               if (div_stat.done) begin
                  vx_ff    <= div_q;
                  state_ff <= S_MY;
               end
            end
            S_MY: state_ff <= S_DY;
            S_DY: state_ff <= S_DYW;
            S_DYW: begin
               if (div_stat.done) begin
                  vy_ff    <= div_q;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  vel_x_ff     <= dx_neg_ff ? 32'(-{12'd0, vx_db}) : {12'd0, vx_db};
                  vel_y_ff     <= dy_neg_ff ? 32'(-{12'd0, vy_db}) : {12'd0, vy_db};
                  turn_ff      <= e_neg_ff ? 32'(-{1'b0, w_db}) : {1'b0, w_db};
                  still_ff     <= moving_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vel_x        = vel_x_ff;
   assign rsp_vel_y        = vel_y_ff;
   assign rsp_turn_rate    = turn_ff;
   assign rsp_still_moving = still_ff;
endmodule
`default_nettype wire

### tb/sv/go_to_pose_velocity_controller_unit_tb.sv
// Self-checking testbench for go_to_pose_velocity_controller_unit.
// It predicts every goal response with its own fixed-point model and checks them in order.
// Depends on gtpvc_pkg and the RTL in hw/rtl.
`timescale 1ns / 100ps
`default_nettype none
module go_to_pose_velocity_controller_unit_tb;
   localparam int PERIOD_NS = 10;
   localparam int DRAIN_CYCLES = 150;
   localparam int PHASE_ITEMS = 110;
   localparam logic [gtpvc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [gtpvc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] turn_rate;
      logic               still_moving;
   } velocity_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = gtpvc_pkg::MODE_ODOM;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [15:0] req_angle = '0;
   logic [30:0] req_tolerance = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_vel_x;
   logic signed [31:0] rsp_vel_y;
   logic signed [31:0] rsp_turn_rate;
   logic rsp_still_moving;
   logic csr_wen = 1'b0;
   logic [gtpvc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gtpvc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   go_to_pose_velocity_controller_unit dut (.*);

   // Predictor copy of the configuration and the stored pose.
   logic [15:0] gain_lin, gain_head;
   logic [19:0] lin_floor, lin_speed, turn_floor;
   logic signed [31:0] odo_x, odo_y;
   logic signed [15:0] odo_heading;

   velocity_cmd_type pending_cmds[$];
   int  error_count = 0;
   int  words_sent = 0;
   int  cmds_checked = 0;
   int  hold_cycles = 0;
   bit  idle_en = 1'b1;

   initial begin
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("[go_to_pose_velocity_controller_unit] ERROR");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] apply_sign(longint unsigned mag, bit neg);
      longint unsigned v;
      v = neg ? (64'd0 - mag) : mag;
      return v[31:0];
   endfunction

   // Velocity command for a goal word against the current pose and settings.
   function automatic velocity_cmd_type predict_command(logic signed [31:0] gx,
         logic signed [31:0] gy, logic signed [15:0] gangle, logic [30:0] tol);
      velocity_cmd_type c;
      longint dx, dy, e;
      longint unsigned ax, ay, big, m, vx, vy, w, tl;
      longint unsigned lim;
      lim = 64'd1 << 31;
      dx = longint'(gx) - longint'(odo_x);
      dy = longint'(gy) - longint'(odo_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      tl = tol;
      vx = 0;
      vy = 0;
      if (ax >= lim || ay >= lim) c.still_moving = 1'b1;
      else c.still_moving = (ax * ax + ay * ay) > (tl * tl);
      if (gain_lin != 0 && (ax | ay) != 0) begin
         big = (ax > ay) ? ax : ay;
         if (big >= lim) begin
            ax >>= 1;
            ay >>= 1;
         end else begin
            while (big < (64'd1 << 30)) begin
               big <<= 1;
               ax <<= 1;
               ay <<= 1;
            end
         end
         m = int_sqrt(ax * ax + ay * ay);
         vx = (64'(lin_speed) * ax) / m;
         vy = (64'(lin_speed) * ay) / m;
      end
      if (vx < lin_floor) vx = 0;
      if (vy < lin_floor) vy = 0;
      e = longint'(gangle) - longint'(odo_heading);
      w = ((((e < 0) ? -e : e) * 64'(gain_head)) >> gtpvc_pkg::W_RS) << gtpvc_pkg::W_LS;
      if (w > lim - 1) w = lim - 1;
      if (w < turn_floor) w = 0;
      c.vel_x = apply_sign(vx, dx < 0);
      c.vel_y = apply_sign(vy, dy < 0);
      c.turn_rate = apply_sign(w, e < 0);
      return c;
   endfunction

   // Offer one word, hold it until accepted, then update the prediction.
   task automatic send_word(logic mode, logic signed [31:0] x, logic signed [31:0] y,
         logic signed [15:0] a, logic [30:0] tol);
      logic accepted;
      if (idle_en && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_coord_x <= x;
      req_coord_y <= y;
      req_angle <= a;
      req_tolerance <= tol;
      // sample ready mid-cycle, where it holds its value for the coming edge
      do begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end while (!accepted);
      words_sent++;
      if (mode == gtpvc_pkg::MODE_GOAL) begin
         pending_cmds.insert(pending_cmds.size(), predict_command(x, y, a, tol));
      end else begin
         odo_x = x;
         odo_y = y;
         odo_heading = a;
      end
   endtask

   // Drop valid, wait for every response plus the sequencer latency.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [gtpvc_pkg::CSR_IDX_W-1:0] idx,
         logic [gtpvc_pkg::CSR_DATA_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         gtpvc_pkg::CSR_LINEAR_GAIN:  gain_lin = val[15:0];
         gtpvc_pkg::CSR_HEADING_GAIN: gain_head = val[15:0];
         gtpvc_pkg::CSR_MIN_LINEAR:   lin_floor = val;
         gtpvc_pkg::CSR_MAX_LINEAR:   lin_speed = val;
         gtpvc_pkg::CSR_MIN_TURN:     turn_floor = val;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [15:0] lg, logic [15:0] hg, logic [19:0] mnl,
         logic [19:0] mxl, logic [19:0] mnt);
      write_csr(gtpvc_pkg::CSR_LINEAR_GAIN, 20'(lg));
      write_csr(gtpvc_pkg::CSR_HEADING_GAIN, 20'(hg));
      write_csr(gtpvc_pkg::CSR_MIN_LINEAR, mnl);
      write_csr(gtpvc_pkg::CSR_MAX_LINEAR, mxl);
      write_csr(gtpvc_pkg::CSR_MIN_TURN, mnt);
   endtask

   // Response side: random ready, long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_en || ($urandom_range(99) >= 24);
      end
   end

   // Compare each response taken at the coming edge with the oldest prediction.
   always @(negedge clock) begin
      velocity_cmd_type exp_cmd;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("response with no command pending");
            error_count++;
         end else begin
            exp_cmd = pending_cmds.pop_front();
            cmds_checked++;
            if (rsp_vel_x !== exp_cmd.vel_x) begin
               $error("vel_x expected %0d got %0d", exp_cmd.vel_x, rsp_vel_x);
               error_count++;
            end
            if (rsp_vel_y !== exp_cmd.vel_y) begin
               $error("vel_y expected %0d got %0d", exp_cmd.vel_y, rsp_vel_y);
               error_count++;
            end
            if (rsp_turn_rate !== exp_cmd.turn_rate) begin
               $error("turn_rate expected %0d got %0d", exp_cmd.turn_rate, rsp_turn_rate);
               error_count++;
            end
            if (rsp_still_moving !== exp_cmd.still_moving) begin
               $error("still_moving expected %0b got %0b",
                      exp_cmd.still_moving, rsp_still_moving);
               error_count++;
            end
         end
      end
   end

   // Reset values: goals from the origin pose.
   task automatic test_reset_defaults();
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd65536, 32'sd0, 16'sd4096, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd0, 32'sd0, 16'sd0, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, -32'sd65536, 32'sd131072, -16'sd100, 31'd200000);
      wait_idle();
   endtask

   // Coordinate, heading and tolerance extremes, incl. distances past 2^31.
   task automatic test_extremes();
      write_all(16'hFFFF, 16'hFFFF, 20'd0, 20'hFFFFF, 20'd0);
      send_word(gtpvc_pkg::MODE_ODOM, 32'sh80000000, 32'sh80000000, 16'sh8000, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF,
                31'h7FFFFFFF);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000,
                31'h7FFFFFFF);
      send_word(gtpvc_pkg::MODE_ODOM, 32'sh7FFFFFFF, 32'sd0, 16'sh7FFF, 31'h7FFFFFFF);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sh80000000, 32'sd1, 16'sh8000, 31'd5);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sh7FFFFFFF, 32'sd0, 16'sh7FFF, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sh7FFFFFFE, -32'sd1, 16'sh7FFE, 31'd1);
      send_word(gtpvc_pkg::MODE_ODOM, 32'sd0, 32'sd0, 16'sd0, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd3, 32'sd4, 16'sd1, 31'd5);   // exactly on tolerance
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd3, 32'sd4, -16'sd1, 31'd4);
      wait_idle();
   endtask

   // Deadbands, zero linear gain and zero speed.
   task automatic test_deadband_and_gain();
      write_all(16'd0, 16'd256, 20'd3277, 20'd13107, 20'd65536);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd70000, -32'sd9000, 16'sd4096, 31'd10);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd70000, -32'sd9000, 16'sd4095, 31'd10);
      wait_idle();
      write_all(16'd1, 16'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd100, 32'sd100, 16'sd1000, 31'd0);
      send_word(gtpvc_pkg::MODE_GOAL, 32'sd100, 32'sd0, -16'sd1000, 31'd0);
      wait_idle();
      write_all(16'd256, 16'd512, 20'd1000, 20'd0, 20'd300);
      write_csr(CSR_SPARE_LO, 20'hFFFFF);   // out-of-range indexes: ignored
      write_csr(CSR_SPARE_HI, 20'd0);
      send_word(gtpvc_pkg::MODE_GOAL, -32'sd100, 32'sd7, 16'sd2, 31'd3);
      wait_idle();
   endtask

   // Hold the response side off so the block fills and stalls req_ready.
   task automatic test_backpressure();
      write_all(16'd256, 16'd512, 20'd3277, 20'd13107, 20'd0);
      hold_cycles = 400;
      repeat (6) send_word(gtpvc_pkg::MODE_GOAL, 32'($urandom), 32'($urandom),
                           16'($urandom), 31'($urandom));
      wait_idle();
   endtask

   task automatic random_phase(bit quiet);
      int n;
      logic signed [31:0] gx, gy;
      idle_en = !quiet;
      for (n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(99) < 30) begin
            send_word(gtpvc_pkg::MODE_ODOM, 32'($urandom), 32'($urandom), 16'($urandom),
                      31'($urandom));
         end else begin
            if ($urandom_range(1)) begin
               gx = 32'($urandom);
               gy = 32'($urandom);
            end else begin
               gx = odo_x + $signed(32'($urandom_range(400000))) - 32'sd200000;
               gy = odo_y + $signed(32'($urandom_range(400000))) - 32'sd200000;
            end
            send_word(gtpvc_pkg::MODE_GOAL, gx, gy, 16'($urandom),
                      $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(300000)));
         end
      end
      wait_idle();
      idle_en = 1'b1;
   endtask

   task automatic test_random();
      int p;
      for (p = 0; p < 5; p++) begin
         if (p == 0) write_all(16'd256, 16'd512, 20'd3277, 20'd13107, 20'd0);
         else if (p == 4) write_all(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
         else write_all(16'($urandom), 16'($urandom), 20'($urandom_range(20000)),
                        20'($urandom), 20'($urandom_range(200000)));
         random_phase(p == 2);
      end
   endtask

   initial begin
      gain_lin = 16'd256;
      gain_head = 16'd512;
      lin_floor = 20'd3277;
      lin_speed = 20'd13107;
      turn_floor = 20'd0;
      odo_x = '0;
      odo_y = '0;
      odo_heading = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      test_deadband_and_gain();
      test_backpressure();
      test_random();
      $display("Sent %0d words and checked %0d velocity commands across", words_sent,
               cmds_checked);
      $display("reset, extreme, deadband, stall and random-gain settings.");
      if (error_count == 0) begin
         $display("[go_to_pose_velocity_controller_unit] OK");
      end else begin
         $display("[go_to_pose_velocity_controller_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

### go_to_pose_velocity_controller_unit.f
hw/rtl/gtpvc_pkg.sv
hw/rtl/gtpvc_mul.sv
hw/rtl/gtpvc_sqrt.sv
hw/rtl/gtpvc_div.sv
hw/rtl/go_to_pose_velocity_controller_unit.sv
tb/sv/go_to_pose_velocity_controller_unit_tb.sv
